@@ rtl/bpfa_pkg.sv @@
package bpfa_pkg;

  localparam int CFG_W           = 12;
  localparam int WORD_W          = 32;
  localparam int BIT_W           = $clog2(WORD_W);
  localparam int FRAMES_DEF      = 2048;
  localparam int SLOTS_DEF       = 1024;
  localparam int RESERVED_FRAMES = 1024;
  localparam int RESET_FIRST     = 1024;
  localparam int RESET_COUNT     = 2048;
  localparam int HEAP_VPN        = 1024;
  localparam int PAGE_SHIFT      = 12;
  localparam int FRAME_OUT_W     = 11;
  localparam int SLOT_OUT_W      = 10;
  localparam int VPN_W           = 11;
  localparam int VA_W            = VPN_W + PAGE_SHIFT;
  localparam int STATUS_W        = 2;
  localparam int CFG_IDX_W       = 1;

  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [WORD_W-1:0]    word_t;

  localparam status_t ST_ALLOC    = 2'd0;
  localparam status_t ST_NO_FRAME = 2'd1;
  localparam status_t ST_NO_SLOT  = 2'd2;
  localparam status_t ST_IDLE     = 2'd3;

  localparam cfg_idx_t CFG_FIRST_FREE  = 1'd0;
  localparam cfg_idx_t CFG_FRAME_COUNT = 1'd1;

  // reset image of one bitmap word: kernel frames marked used
  function automatic word_t reserved_word(input int widx);
    word_t w;
    w = '0;
    for (int i = 0; i < WORD_W; i++) begin
      w[i] = ((widx * WORD_W + i) < RESERVED_FRAMES);
    end
    return w;
  endfunction

endpackage

@@ rtl/bpfa_if.sv @@
interface bpfa_req_if;
  import bpfa_pkg::*;
  logic valid;
  logic ready;
  logic request;

  modport source (output valid, output request, input ready);
  modport sink   (input valid, input request, output ready);
endinterface

interface bpfa_rsp_if;
  import bpfa_pkg::*;
  logic                   valid;
  logic                   ready;
  status_t                status;
  logic [FRAME_OUT_W-1:0] frame_index;
  logic [SLOT_OUT_W-1:0]  slot_index;
  logic [VA_W-1:0]        virtual_address;

  modport source (output valid, output status, output frame_index, output slot_index,
                  output virtual_address, input ready);
  modport sink   (input valid, input status, input frame_index, input slot_index,
                  input virtual_address, output ready);
endinterface

@@ rtl/bitmap_page_frame_allocator_unit.sv @@
// Bitmap page frame allocator.
// in_ch carries one word per request: request=1 asks for a page, request=0 is an
// idle word answered with status idle. out_ch returns exactly one word per input
// word: status, frame_index, slot_index and virtual_address (fields zero unless
// status is allocated). cfg_we/cfg_index/cfg_wdata set the first searched frame
// and the frame count; write them only while no request is in flight.
// Frame and slot bitmaps sit in two RAMs of 32-bit words, read one word a cycle.
// An allocation reads frame bitmap words until a free frame is found, then slot
// bitmap words until a free slot is found (up to 64 and 32 words at default
// sizes), then sets both bits and loads the result word; an idle word or a
// request with an empty frame range goes straight to its result. Only one
// word is worked on at a time; the next word can be accepted in the cycle
// after the result is loaded. After reset a clearing pass writes the reset
// bitmap images to every word of both RAMs; in_ch.ready stays low meanwhile.
// A result waits in the output register while out_ch.ready is low; the next
// input word is still accepted and worked on up to its own result.
module bitmap_page_frame_allocator_unit #(
  parameter int FRAMES = bpfa_pkg::FRAMES_DEF,
  parameter int SLOTS  = bpfa_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bpfa_req_if.sink                    in_ch,
  bpfa_rsp_if.source                  out_ch,
  input  logic                        cfg_we,
  input  bpfa_pkg::cfg_idx_t          cfg_index,
  input  logic [bpfa_pkg::CFG_W-1:0]  cfg_wdata
);
  import bpfa_pkg::*;

  localparam int FRAME_W = $clog2(FRAMES);
  localparam int LIM_W   = $clog2(FRAMES + 1);
  localparam int FW_N    = (FRAMES + WORD_W - 1) / WORD_W;
  localparam int FWA_W   = FRAME_W - BIT_W;
  localparam int SW_N    = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int SWA_W   = (SW_N > 1) ? $clog2(SW_N) : 1;
  localparam int SLW     = (SLOTS - 1) / WORD_W;
  localparam int SLB     = (SLOTS - 1) % WORD_W;
  localparam int AW      = (FWA_W > SWA_W) ? FWA_W : SWA_W;
  localparam int CLR_N   = (FW_N > SW_N) ? FW_N : SW_N;

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FSCAN  = 3'd2;
  localparam logic [2:0] S_SSCAN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [CFG_W-1:0]       first_r, first_nxt;
  logic [CFG_W-1:0]       count_r, count_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [AW-1:0]          daddr_r, daddr_nxt;
  logic                   dv_r, dv_nxt;
  word_t                  fword_r, fword_nxt;
  logic [FWA_W-1:0]       fwaddr_r, fwaddr_nxt;
  logic [BIT_W-1:0]       fbit_r, fbit_nxt;
  word_t                  sword_r, sword_nxt;
  logic [SWA_W-1:0]       swaddr_r, swaddr_nxt;
  logic [BIT_W-1:0]       sbit_r, sbit_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [FRAME_OUT_W-1:0] res_frame_r, res_frame_nxt;
  logic [SLOT_OUT_W-1:0]  res_slot_r, res_slot_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [FRAME_OUT_W-1:0] out_frame_r, out_frame_nxt;
  logic [SLOT_OUT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [VA_W-1:0]        out_va_r, out_va_nxt;

  logic [LIM_W-1:0]       limit;
  logic [FRAME_W-1:0]     lim_m1;
  logic [FWA_W-1:0]       fw_first;
  logic [FWA_W-1:0]       fw_last;
  logic [FWA_W-1:0]       addr_f, daddr_f;
  logic [SWA_W-1:0]       addr_s, daddr_s;
  logic                   range_empty;
  logic                   f_issue, s_issue;
  logic                   f_hit, s_hit;
  logic [BIT_W-1:0]       f_bit, s_bit;
  logic [VPN_W-1:0]       vpn;

  logic                   fram_we, fram_re;
  logic [FWA_W-1:0]       fram_waddr;
  word_t                  fram_wdata, fram_rdata;
  logic                   sram_we, sram_re;
  logic [SWA_W-1:0]       sram_waddr;
  word_t                  sram_wdata, sram_rdata;

  bpfa_ram #(.WIDTH(WORD_W), .DEPTH(FW_N)) u_frame_ram (
    .clk   (clk),
    .we    (fram_we),
    .waddr (fram_waddr),
    .wdata (fram_wdata),
    .re    (fram_re),
    .raddr (addr_f),
    .rdata (fram_rdata)
  );

  bpfa_ram #(.WIDTH(WORD_W), .DEPTH(SW_N)) u_slot_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (sram_wdata),
    .re    (sram_re),
    .raddr (addr_s),
    .rdata (sram_rdata)
  );

  bpfa_word_find u_frame_find (
    .used    (fram_rdata),
    .lo_en   (daddr_f == fw_first),
    .lo      (first_r[BIT_W-1:0]),
    .hi_en   (daddr_f == fw_last),
    .hi      (lim_m1[BIT_W-1:0]),
    .hit     (f_hit),
    .bit_idx (f_bit)
  );

  bpfa_word_find u_slot_find (
    .used    (sram_rdata),
    .lo_en   (1'b0),
    .lo      ('0),
    .hi_en   (daddr_s == SWA_W'(SLW)),
    .hi      (BIT_W'(SLB)),
    .hit     (s_hit),
    .bit_idx (s_bit)
  );

  always_comb begin
    limit       = (32'(count_r) > FRAMES) ? LIM_W'(FRAMES) : LIM_W'(count_r);
    lim_m1      = FRAME_W'(limit - 1'b1);
    fw_first    = FWA_W'(first_r >> BIT_W);
    fw_last     = lim_m1[FRAME_W-1:BIT_W];
    range_empty = (32'(first_r) >= 32'(limit));
    addr_f      = addr_r[FWA_W-1:0];
    daddr_f     = daddr_r[FWA_W-1:0];
    addr_s      = addr_r[SWA_W-1:0];
    daddr_s     = daddr_r[SWA_W-1:0];
    f_issue     = (state_r == S_FSCAN) && (addr_f <= fw_last);
    s_issue     = (state_r == S_SSCAN) && (addr_s <= SWA_W'(SLW));
    fram_re     = f_issue;
    sram_re     = s_issue;
    vpn         = VPN_W'(HEAP_VPN) + VPN_W'({swaddr_r, sbit_r});
    in_ch.ready = (state_r == S_IDLE);

    fram_we    = 1'b0;
    fram_waddr = fwaddr_r;
    fram_wdata = fword_r | (word_t'(1) << fbit_r);
    sram_we    = 1'b0;
    sram_waddr = swaddr_r;
    sram_wdata = sword_r | (word_t'(1) << sbit_r);

    state_nxt      = state_r;
    first_nxt      = first_r;
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    daddr_nxt      = daddr_r;
    dv_nxt         = dv_r;
    fword_nxt      = fword_r;
    fwaddr_nxt     = fwaddr_r;
    fbit_nxt       = fbit_r;
    sword_nxt      = sword_r;
    swaddr_nxt     = swaddr_r;
    sbit_nxt       = sbit_r;
    res_status_nxt = res_status_r;
    res_frame_nxt  = res_frame_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    out_slot_nxt   = out_slot_r;
    out_va_nxt     = out_va_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_FREE:  first_nxt = cfg_wdata;
        CFG_FRAME_COUNT: count_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_CLR: begin
        fram_we    = (32'(addr_r) < FW_N);
        fram_waddr = addr_f;
        fram_wdata = reserved_word(32'(addr_r));
        sram_we    = (32'(addr_r) < SW_N);
        sram_waddr = addr_s;
        sram_wdata = '0;
        addr_nxt   = addr_r + 1'b1;
        if (32'(addr_r) == CLR_N - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        addr_nxt       = AW'(fw_first);
        dv_nxt         = 1'b0;
        res_frame_nxt  = '0;
        res_slot_nxt   = '0;
        if (in_ch.valid) begin
          if (!in_ch.request) begin
            res_status_nxt = ST_IDLE;
            state_nxt      = S_DONE;
          end else if (range_empty) begin
            res_status_nxt = ST_NO_FRAME;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_FSCAN;
          end
        end
      end
      S_FSCAN: begin
        if (dv_r && f_hit) begin
          fword_nxt  = fram_rdata;
          fwaddr_nxt = daddr_f;
          fbit_nxt   = f_bit;
          addr_nxt   = '0;
          dv_nxt     = 1'b0;
          state_nxt  = S_SSCAN;
        end else if (dv_r && (daddr_f == fw_last)) begin
          res_status_nxt = ST_NO_FRAME;
          state_nxt      = S_DONE;
        end else begin
          dv_nxt    = f_issue;
          daddr_nxt = addr_r;
          if (f_issue) begin
            addr_nxt = addr_r + 1'b1;
          end
        end
      end
      S_SSCAN: begin
        if (dv_r && s_hit) begin
          sword_nxt  = sram_rdata;
          swaddr_nxt = daddr_s;
          sbit_nxt   = s_bit;
          state_nxt  = S_COMMIT;
        end else if (dv_r && (daddr_s == SWA_W'(SLW))) begin
          res_status_nxt = ST_NO_SLOT;
          state_nxt      = S_DONE;
        end else begin
          dv_nxt    = s_issue;
          daddr_nxt = addr_r;
          if (s_issue) begin
            addr_nxt = addr_r + 1'b1;
          end
        end
      end
      S_COMMIT: begin
        fram_we        = 1'b1;
        sram_we        = 1'b1;
        res_status_nxt = ST_ALLOC;
        res_frame_nxt  = FRAME_OUT_W'({fwaddr_r, fbit_r});
        res_slot_nxt   = SLOT_OUT_W'({swaddr_r, sbit_r});
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_frame_nxt  = res_frame_r;
          out_slot_nxt   = res_slot_r;
          out_va_nxt     = (res_status_r == ST_ALLOC) ? {vpn, PAGE_SHIFT'(0)} : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      first_r     <= CFG_W'(RESET_FIRST);
      count_r     <= CFG_W'(RESET_COUNT);
      addr_r      <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      count_r     <= count_nxt;
      addr_r      <= addr_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    daddr_r      <= daddr_nxt;
    fword_r      <= fword_nxt;
    fwaddr_r     <= fwaddr_nxt;
    fbit_r       <= fbit_nxt;
    sword_r      <= sword_nxt;
    swaddr_r     <= swaddr_nxt;
    sbit_r       <= sbit_nxt;
    res_status_r <= res_status_nxt;
    res_frame_r  <= res_frame_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
    out_slot_r   <= out_slot_nxt;
    out_va_r     <= out_va_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.frame_index     = out_frame_r;
  assign out_ch.slot_index      = out_slot_r;
  assign out_ch.virtual_address = out_va_r;

endmodule

@@ rtl/bpfa_ram.sv @@
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bpfa_word_find.sv @@
module bpfa_word_find (
  input  bpfa_pkg::word_t              used,
  input  logic                         lo_en,
  input  logic [bpfa_pkg::BIT_W-1:0]   lo,
  input  logic                         hi_en,
  input  logic [bpfa_pkg::BIT_W-1:0]   hi,
  output logic                         hit,
  output logic [bpfa_pkg::BIT_W-1:0]   bit_idx
);
  import bpfa_pkg::*;

  word_t lo_mask;
  word_t hi_mask;
  word_t free_bits;

  always_comb begin
    lo_mask   = lo_en ? ('1 << lo) : '1;
    hi_mask   = hi_en ? ('1 >> (BIT_W'(WORD_W - 1) - hi)) : '1;
    free_bits = ~used & lo_mask & hi_mask;
    hit       = |free_bits;
    bit_idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        bit_idx = BIT_W'(i);
      end
    end
  end

endmodule

@@ verif/page_grant_checker.sv @@
`timescale 1ns / 1ps
module page_grant_checker #(
  parameter int FRAMES = bpfa_pkg::FRAMES_DEF,
  parameter int SLOTS  = bpfa_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bpfa_req_if                        in_mon,
  bpfa_rsp_if                        out_mon,
  input  logic                       cfg_we,
  input  bpfa_pkg::cfg_idx_t         cfg_index,
  input  logic [bpfa_pkg::CFG_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         outstanding
);
  import bpfa_pkg::*;

  typedef struct packed {
    status_t                status;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic [SLOT_OUT_W-1:0]  slot_index;
    logic [VA_W-1:0]        virtual_address;
  } grant_t;

  logic [CFG_W-1:0]       first_frame;
  logic [CFG_W-1:0]       frame_total;
  bit                     frame_used [FRAMES];
  bit                     slot_present [SLOTS];
  logic [FRAME_OUT_W-1:0] slot_frame [SLOTS];
  grant_t                 pending_grants [$];
  int                     failures;

  function automatic grant_t allocate_page(input logic req);
    grant_t g;
    int     limit;
    int     frame;
    int     slot;
    g = '0;
    g.status = ST_IDLE;
    if (!req) return g;
    limit = (int'(frame_total) > FRAMES) ? FRAMES : int'(frame_total);
    frame = -1;
    for (int f = int'(first_frame); f < limit; f++) begin
      if (!frame_used[f]) begin
        frame = f;
        break;
      end
    end
    if (frame < 0) begin
      g.status = ST_NO_FRAME;
      return g;
    end
    slot = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (!slot_present[s]) begin
        slot = s;
        break;
      end
    end
    if (slot < 0) begin
      g.status = ST_NO_SLOT;
      return g;
    end
    // both searches hit: commit
    frame_used[frame]   = 1'b1;
    slot_present[slot]  = 1'b1;
    slot_frame[slot]    = FRAME_OUT_W'(frame);
    g.status            = ST_ALLOC;
    g.frame_index       = FRAME_OUT_W'(frame);
    g.slot_index        = SLOT_OUT_W'(slot);
    g.virtual_address   = VA_W'((HEAP_VPN + slot) << PAGE_SHIFT);
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    if (!rst_n) begin
      first_frame = CFG_W'(RESET_FIRST);
      frame_total = CFG_W'(RESET_COUNT);
      for (int f = 0; f < FRAMES; f++) frame_used[f] = (f < RESERVED_FRAMES);
      for (int s = 0; s < SLOTS; s++) begin
        slot_present[s] = 1'b0;
        slot_frame[s]   = '0;
      end
      pending_grants.delete();
      failures = 0;
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status          = out_mon.status;
        got.frame_index     = out_mon.frame_index;
        got.slot_index      = out_mon.slot_index;
        got.virtual_address = out_mon.virtual_address;
        if (pending_grants.size() == 0) begin
          if (failures < 10)
            $display("%0t: unexpected word: status %0d frame %0d slot %0d va 0x%06h",
                     $realtime, got.status, got.frame_index, got.slot_index,
                     got.virtual_address);
          failures++;
        end else begin
          want = pending_grants.pop_front();
          if (got.status !== want.status || got.frame_index !== want.frame_index ||
              got.slot_index !== want.slot_index ||
              got.virtual_address !== want.virtual_address) begin
            if (failures < 10)
              $display({"%0t: mismatch: exp status %0d frame %0d slot %0d va 0x%06h,",
                        " got status %0d frame %0d slot %0d va 0x%06h"},
                       $realtime, want.status, want.frame_index, want.slot_index,
                       want.virtual_address, got.status, got.frame_index,
                       got.slot_index, got.virtual_address);
            failures++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_grants.push_back(allocate_page(in_mon.request));
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_FREE:  first_frame = cfg_wdata;
          CFG_FRAME_COUNT: frame_total = cfg_wdata;
          default: ;
        endcase
      end
      fail_count  <= failures;
      outstanding <= pending_grants.size();
    end
  end

endmodule

@@ verif/bitmap_page_frame_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
module bitmap_page_frame_allocator_unit_tb;
  import bpfa_pkg::*;

  localparam int RANDOM_WORDS = 800;
  localparam int PHASE_WORDS  = 100;
  localparam int CYCLE_LIMIT  = 600000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int               fail_count;
  int               outstanding;
  bit               quiet;
  int               stall_left;
  int               cycle_count;

  bpfa_req_if in_ch ();
  bpfa_rsp_if out_ch ();

  bitmap_page_frame_allocator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  page_grant_checker u_grant_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_ch.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = pick_gap() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_word(input logic req);
    int gap;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.request <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.request <= req;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_bounds(input int first, input int count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_FREE;
    cfg_wdata <= CFG_W'(first);
    @(posedge clk);
    cfg_index <= CFG_FRAME_COUNT;
    cfg_wdata <= CFG_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int first;
    int count;
    int mode;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_FIRST_FREE;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.request <= 1'b0;
    quiet         <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    // reset bounds: idle word, then first frames above the kernel area
    send_word(1'b0);
    repeat (3) send_word(1'b1);
    settle();
    // count above FRAMES clamps; search from 0 skips the kernel frames
    set_bounds(0, 4095);
    send_word(1'b1);
    settle();
    // last frame only, then out of frames
    set_bounds(2047, 2048);
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b0);
    settle();
    // empty ranges
    set_bounds(2048, 2048);
    send_word(1'b1);
    settle();
    set_bounds(4095, 0);
    send_word(1'b1);
    settle();
    set_bounds(0, 0);
    send_word(1'b1);
    settle();
    // bounds not on byte edges
    set_bounds(1500, 1503);
    repeat (4) send_word(1'b1);
    settle();
    set_bounds(1030, 1031);
    send_word(1'b1);
    settle();
    set_bounds(1028, 1030);
    repeat (3) send_word(1'b1);
    settle();

    for (int p = 0; p < RANDOM_WORDS / PHASE_WORDS; p++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        first = $urandom_range(0, 1100);
        count = $urandom_range(1500, 4095);
      end else if (mode < 9) begin
        first = $urandom_range(1024, 2040);
        count = first + $urandom_range(1, 24);
      end else begin
        first = $urandom_range(2048, 4095);
        count = $urandom_range(0, 4095);
      end
      quiet <= (p % 4 == 3);
      set_bounds(first, count);
      for (int i = 0; i < PHASE_WORDS; i++) send_word($urandom_range(0, 99) < 85);
      settle();
    end

    quiet <= 1'b0;
    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bpfa_pkg.sv
rtl/bpfa_if.sv
rtl/bpfa_ram.sv
rtl/bpfa_word_find.sv
rtl/bitmap_page_frame_allocator_unit.sv
verif/page_grant_checker.sv
verif/bitmap_page_frame_allocator_unit_tb.sv
